// ===== src/rbs_pkg.sv =====
// rbs_pkg: shared types, widths and helpers for the redundant baseline stacker.
// Used by rbs_front, rbs_div, rbs_back and the top level; depends on nothing.
package rbs_pkg;

  localparam int SUM_W  = 48;   // complex sum width, signed Q32.16
  localparam int VAR_W  = 48;   // variance sum width, unsigned Q32.16
  localparam int DIV_NW = 80;   // divider numerator, left aligned
  localparam int DIV_DW = 48;   // divider divisor width
  localparam int DIV_QW = 48;   // kept quotient bits
  localparam int STEP_W = 7;    // divider step counter

  localparam logic [STEP_W-1:0] RECIP_STEPS  = 7'd33;
  localparam logic [STEP_W-1:0] MEAN_STEPS   = 7'd48;
  localparam logic [STEP_W-1:0] WEIGHT_STEPS = 7'd80;

  // Classified work for the back end
  typedef enum logic [1:0] {
    K_ACC = 2'd0,   // accumulate a good product
    K_RD  = 2'd1,   // read out and clear a stack
    K_RDZ = 2'd2    // read out of range: all-zero result
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [9:0]         stack_index;
    logic signed [31:0] vis_re;
    logic signed [31:0] vis_im;
    logic [31:0]        weight;
    logic               flip_conjugate;
  } entry_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t ent;
  } q_head_t;

  // Back end status towards the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  // Saturate a rounded mean magnitude and apply its sign
  function automatic logic [31:0] sat_mean(input logic [DIV_QW-1:0] q, input logic neg);
    logic [DIV_QW-1:0] m;
    begin
      if (neg) begin
        m = (q > 48'h0000_8000_0000) ? 48'h0000_8000_0000 : q;
        sat_mean = 32'(-m);
      end else begin
        m = (q > 48'h0000_7FFF_FFFF) ? 48'h0000_7FFF_FFFF : q;
        sat_mean = m[31:0];
      end
    end
  endfunction

endpackage

// ===== src/redundant_baseline_stacker_core.sv =====
// redundant_baseline_stacker_core: top level of the redundant baseline stacker.
// Depends on rbs_pkg, rbs_front, rbs_back (and rbs_div below it).
//
// Use: drive the item fields and raise start; a beat is taken at a rising edge
// where start is high and busy is low. op 0 accumulates one product into a
// stack, op 1 reads a stack out and clears it. Each readout gives one result:
// done is high for exactly one cycle with mean_re, mean_im, stack_weight and
// product_count valid. Accumulates give no result. The receiver cannot stall.
// Skipped products are dropped in the front end and never queued. A good
// product passes through the back end as pop, memory read, a 33-step
// reciprocal divide and the write. A readout runs at most two 48-step mean
// divides, a multiply and an 80-step weight divide before done rises; empty
// stacks are faster, out-of-range readouts give a zero result after the
// queue ahead drains. All divides run on the one bit-per-cycle divider
// that the back end shares.
// A two-entry queue lets the front take beats while the back end works.
// Reset: a clearing pass writes every stack to zero with busy high; no beat
// is taken until it ends.
module redundant_baseline_stacker_core #(
  parameter int STACKS     = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [9:0]         stack_index,
  input  logic signed [31:0] vis_re,
  input  logic signed [31:0] vis_im,
  input  logic [31:0]        weight,
  input  logic               input_a_good,
  input  logic               input_b_good,
  input  logic               flip_conjugate,
  output logic               done,
  output logic signed [31:0] mean_re,
  output logic signed [31:0] mean_im,
  output logic [31:0]        stack_weight,
  output logic [15:0]        product_count
);

  rbs_pkg::q_head_t    head;
  rbs_pkg::back_stat_t stat;

  rbs_front #(.STACKS(STACKS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .stack_index    (stack_index),
    .vis_re         (vis_re),
    .vis_im         (vis_im),
    .weight         (weight),
    .input_a_good   (input_a_good),
    .input_b_good   (input_b_good),
    .flip_conjugate (flip_conjugate),
    .head           (head),
    .stat           (stat)
  );

  rbs_back #(.STACKS(STACKS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .stat          (stat),
    .done          (done),
    .mean_re       (mean_re),
    .mean_im       (mean_im),
    .stack_weight  (stack_weight),
    .product_count (product_count)
  );

endmodule

// ===== src/rbs_front.sv =====
// rbs_front: accepts beats, drops skipped products and queues work for the back end.
// Depends on rbs_pkg.
module rbs_front #(
  parameter int STACKS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [9:0]          stack_index,
  input  logic signed [31:0]  vis_re,
  input  logic signed [31:0]  vis_im,
  input  logic [31:0]         weight,
  input  logic                input_a_good,
  input  logic                input_b_good,
  input  logic                flip_conjugate,
  output rbs_pkg::q_head_t    head,
  input  rbs_pkg::back_stat_t stat
);

  rbs_pkg::entry_t q_mem [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      fill;
  logic            accept, in_range, skip, push;
  rbs_pkg::entry_t ent_in;

  // Classify the incoming beat
  always_comb begin
    in_range = 32'(stack_index) < 32'(STACKS);
    skip     = (op == 1'b0) &&
               (!in_range || weight == 32'd0 || !input_a_good || !input_b_good);
    ent_in.kind           = (op == 1'b0) ? rbs_pkg::K_ACC :
                            (in_range ? rbs_pkg::K_RD : rbs_pkg::K_RDZ);
    ent_in.stack_index    = stack_index;
    ent_in.vis_re         = vis_re;
    ent_in.vis_im         = vis_im;
    ent_in.weight         = weight;
    ent_in.flip_conjugate = flip_conjugate;
  end

  assign busy   = stat.clearing || (fill == 2'd2);
  assign accept = start && !busy;
  assign push   = accept && !skip;

  assign head.valid = (fill != 2'd0);
  assign head.ent   = q_mem[rd_ptr];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= ent_in;
        wr_ptr        <= ~wr_ptr;
      end
      if (stat.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(stat.pop);
    end
  end

endmodule

// ===== src/rbs_div.sv =====
// rbs_div: restoring divider, one quotient bit per cycle, numerator left aligned.
// Depends on rbs_pkg.
module rbs_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rbs_pkg::DIV_NW-1:0]       num,
  input  logic [rbs_pkg::DIV_DW-1:0]       den,
  input  logic [rbs_pkg::STEP_W-1:0]       steps,
  output logic                             done,
  output logic [rbs_pkg::DIV_QW-1:0]       quo
);

  logic [rbs_pkg::DIV_NW-1:0] nsh;
  logic [rbs_pkg::DIV_DW-1:0] dsr;
  logic [rbs_pkg::DIV_DW-1:0] rem;
  logic [rbs_pkg::STEP_W-1:0] left;
  logic                       run;
  logic [rbs_pkg::DIV_DW:0]   trial;
  logic                       ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem, nsh[rbs_pkg::DIV_NW-1]};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nsh  <= num;
        dsr  <= den;
        rem  <= '0;
        quo  <= '0;
        left <= steps;
        run  <= 1'b1;
      end else if (run) begin
        nsh  <= {nsh[rbs_pkg::DIV_NW-2:0], 1'b0};
        rem  <= ge ? rbs_pkg::DIV_DW'(trial - {1'b0, dsr}) : trial[rbs_pkg::DIV_DW-1:0];
        quo  <= {quo[rbs_pkg::DIV_QW-2:0], ge};
        left <= left - 1'b1;
        if (left == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/rbs_back.sv =====
// rbs_back: stack memory, clearing pass, accumulate and readout sequencer.
// Depends on rbs_pkg and rbs_div.
module rbs_back #(
  parameter int STACKS     = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rbs_pkg::q_head_t    head,
  output rbs_pkg::back_stat_t stat,
  output logic                done,
  output logic signed [31:0]  mean_re,
  output logic signed [31:0]  mean_im,
  output logic [31:0]         stack_weight,
  output logic [15:0]         product_count
);

  localparam int AW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [AW-1:0] LAST = AW'(STACKS - 1);

  typedef struct packed {
    logic signed [rbs_pkg::SUM_W-1:0] sre;
    logic signed [rbs_pkg::SUM_W-1:0] sim;
    logic [rbs_pkg::VAR_W-1:0]        vs;
    logic [COUNT_BITS-1:0]            cnt;
  } stack_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_READ  = 10'b00_0000_0100,
    S_RECIP = 10'b00_0000_1000,
    S_MRE   = 10'b00_0001_0000,
    S_MIM   = 10'b00_0010_0000,
    S_SQR   = 10'b00_0100_0000,
    S_WCHK  = 10'b00_1000_0000,
    S_WT    = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  stack_t          mem [STACKS];
  stack_t          rd_q, wdata;
  logic [AW-1:0]   mem_addr, waddr, clr_addr;
  logic            we;
  state_t          state, state_next;
  rbs_pkg::entry_t ent;
  logic [31:0]     mre, mim, wt;
  logic [63:0]     c2;

  logic                         div_start, div_done;
  logic [rbs_pkg::DIV_NW-1:0]   div_num;
  logic [rbs_pkg::DIV_DW-1:0]   div_den;
  logic [rbs_pkg::STEP_W-1:0]   div_steps;
  logic [rbs_pkg::DIV_QW-1:0]   div_quo;

  logic signed [48:0] vre_x, vim_x, sre_s, sim_s;
  logic [48:0]        vs_s;
  logic [47:0]        mag_re, mag_im, half_c, num_re, num_im;
  logic               neg_re, neg_im, cnt_zero, cnt_full;
  stack_t             acc_new;

  // Memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[mem_addr];
  end

  // Datapath for accumulate and readout
  always_comb begin
    vre_x  = 49'(ent.vis_re);
    vim_x  = ent.flip_conjugate ? -49'(ent.vis_im) : 49'(ent.vis_im);
    sre_s  = 49'(rd_q.sre) + vre_x;
    sim_s  = 49'(rd_q.sim) + vim_x;
    vs_s   = {1'b0, rd_q.vs} + 49'(div_quo[32:0]);
    acc_new.sre = (sre_s[48] != sre_s[47]) ?
                  (sre_s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : sre_s[47:0];
    acc_new.sim = (sim_s[48] != sim_s[47]) ?
                  (sim_s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : sim_s[47:0];
    acc_new.vs  = vs_s[48] ? {48{1'b1}} : vs_s[47:0];
    acc_new.cnt = rd_q.cnt + 1'b1;
    neg_re   = rd_q.sre[47];
    neg_im   = rd_q.sim[47];
    mag_re   = neg_re ? 48'(-rd_q.sre) : 48'(rd_q.sre);
    mag_im   = neg_im ? 48'(-rd_q.sim) : 48'(rd_q.sim);
    half_c   = 48'(rd_q.cnt >> 1);
    num_re   = mag_re + half_c;
    num_im   = mag_im + half_c;
    cnt_zero = (rd_q.cnt == '0);
    cnt_full = (rd_q.cnt == '1);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    stat.pop      = 1'b0;
    stat.clearing = (state == S_CLEAR);
    we         = 1'b0;
    waddr      = AW'(ent.stack_index);
    wdata      = '0;
    mem_addr   = AW'(ent.stack_index);
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = 48'(rd_q.cnt);
    div_steps  = rbs_pkg::MEAN_STEPS;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        mem_addr = AW'(head.ent.stack_index);
        if (head.valid) begin
          stat.pop = 1'b1;
          if (head.ent.kind != rbs_pkg::K_RDZ) state_next = S_READ;
        end
      end
      S_READ: begin
        if (ent.kind == rbs_pkg::K_ACC) begin
          if (cnt_full) begin
            state_next = S_IDLE;
          end else begin
            div_start  = 1'b1;
            div_num    = {33'h1_0000_0000, 47'd0};
            div_den    = 48'(ent.weight);
            div_steps  = rbs_pkg::RECIP_STEPS;
            state_next = S_RECIP;
          end
        end else if (cnt_zero) begin
          state_next = S_SQR;
        end else begin
          div_start  = 1'b1;
          div_num    = {num_re, 32'd0};
          state_next = S_MRE;
        end
      end
      S_RECIP: begin
        if (div_done) begin
          we         = 1'b1;
          wdata      = acc_new;
          state_next = S_IDLE;
        end
      end
      S_MRE: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = {num_im, 32'd0};
          state_next = S_MIM;
        end
      end
      S_MIM: begin
        if (div_done) state_next = S_SQR;
      end
      S_SQR: state_next = S_WCHK;
      S_WCHK: begin
        if (rd_q.vs != '0 && c2 < 64'(rd_q.vs)) begin
          div_start  = 1'b1;
          div_num    = {c2[47:0], 32'd0};
          div_den    = rd_q.vs;
          div_steps  = rbs_pkg::WEIGHT_STEPS;
          state_next = S_WT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WT: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        we         = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  rbs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_IDLE && head.valid) begin
        ent <= head.ent;
        if (head.ent.kind == rbs_pkg::K_RDZ) begin
          done          <= 1'b1;
          mean_re       <= '0;
          mean_im       <= '0;
          stack_weight  <= '0;
          product_count <= '0;
        end
      end
      // Readout working values
      if (state == S_READ) begin
        mre <= '0;
        mim <= '0;
      end
      if (state == S_MRE && div_done) mre <= rbs_pkg::sat_mean(div_quo, neg_re);
      if (state == S_MIM && div_done) mim <= rbs_pkg::sat_mean(div_quo, neg_im);
      if (state == S_SQR) c2 <= 64'(rd_q.cnt) * 64'(rd_q.cnt);
      if (state == S_WCHK) wt <= (rd_q.vs == '0) ? 32'd0 : 32'hFFFF_FFFF;
      if (state == S_WT && div_done) wt <= div_quo[31:0];
      if (state == S_OUT) begin
        done          <= 1'b1;
        mean_re       <= mre;
        mean_im       <= mim;
        stack_weight  <= wt;
        product_count <= (33'(rd_q.cnt) > 33'h0FFFF) ? 16'hFFFF : 16'(rd_q.cnt);
      end
    end
  end

endmodule

// ===== src/rbs_checker.sv =====
// rbs_checker: port-level checks on the stacker, bound to the top level.
// Depends on redundant_baseline_stacker_core ports only.
module rbs_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] mean_re,
  input logic signed [31:0] mean_im,
  input logic [31:0]        stack_weight,
  input logic [15:0]        product_count
);

  // Reset starts the clearing pass
  a_clear_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // No result straight out of reset
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  // An empty stack reads as all zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && product_count == 16'd0) |->
      (mean_re == 32'sd0 && mean_im == 32'sd0 && stack_weight == 32'd0))
    else $error("empty stack gave a non-zero result");

endmodule

bind redundant_baseline_stacker_core rbs_checker u_rbs_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .done          (done),
  .mean_re       (mean_re),
  .mean_im       (mean_im),
  .stack_weight  (stack_weight),
  .product_count (product_count)
);
